[hdl/r2q_pkg.sv]
package r2q_pkg;

    // Field widths of the stream channels.
    localparam int IN_FIELD_W  = 16;
    localparam int NUM_ELEM    = 9;
    localparam int IN_DATA_W   = IN_FIELD_W * NUM_ELEM;
    localparam int OUT_FIELD_W = 16;
    localparam int OUT_DATA_W  = 4 * OUT_FIELD_W;
    localparam int TUSER_W     = 3;
    localparam int TUSER_DEGEN = 2;

    // Branch chosen as the largest of trace and diagonal.
    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_M00   = 2'd1,
        BR_M11   = 2'd2,
        BR_M22   = 2'd3
    } branch_t;

endpackage

[hdl/rotation_matrix_to_quaternion.sv]
// Channel  Dir  Fields (lowest bits first)
// s_*      in   tdata: m00 m01 m02 m10 m11 m12 m20 m21 m22, 16 bits each
// m_*      out  tdata: quat_w quat_x quat_y quat_z, 16 bits each
//               tuser: branch_taken (2 bits), degenerate (1 bit)
//
// One request enters per cycle while the output is not stalled. The square root yields one
// root bit per stage, H being half its operand width, and DW = 18 + FRAC_BITS is the
// dividend width of the three restoring dividers (one quotient bit per stage).
// Reset clears only the valid bits. When the output holds an untaken result the
// whole pipeline freezes; nothing is lost or repeated.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS     = 14,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // m00 m01 m02 m10 m11 m12 m20 m21 m22
    input  logic [r2q_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // quat_w quat_x quat_y quat_z
    output logic [r2q_pkg::OUT_DATA_W-1:0]  m_tdata,
    // branch_taken degenerate
    output logic [r2q_pkg::TUSER_W-1:0]     m_tuser
);
    import r2q_pkg::*;

    localparam int EW  = (ELEMENT_WIDTH < IN_FIELD_W) ? ELEMENT_WIDTH : IN_FIELD_W;
    localparam int IW  = IN_FIELD_W + 1;
    localparam int NSW = IW + 1;
    localparam int TW  = IW + 2;
    localparam int RB  = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 2;
    localparam int RSW = RB + 1;
    localparam int XW  = ((RB + FRAC_BITS + 1) / 2) * 2;
    localparam int H   = XW / 2;
    localparam int RMW = H + 2;
    localparam int DW  = NSW + FRAC_BITS;
    localparam logic [63:0] LIMIT = 64'd1 << (ELEMENT_WIDTH - 1);

    typedef struct packed {
        branch_t                br;
        logic                   dg;
        logic signed [NSW-1:0]  n0;
        logic signed [NSW-1:0]  n1;
        logic signed [NSW-1:0]  n2;
    } side_t;

    typedef struct packed {
        logic [XW-1:0]  x;
        logic [RMW-1:0] rem;
        logic [H-1:0]   root;
    } sq_t;

    typedef struct packed {
        logic [DW-1:0] d;
        logic [H:0]    rem;
        logic [DW-1:0] q;
    } dv_t;

    typedef struct packed {
        branch_t      br;
        logic         dg;
        logic [H:0]   den;
        logic [H-2:0] prim;
        logic [2:0]   neg;
    } dside_t;

    // Sign or zero extension of one input field to the internal width.
    function automatic logic signed [IW-1:0] ext_elem(input logic [IN_FIELD_W-1:0] f);
        logic sgn;
        sgn = (ELEMENT_WIDTH <= IN_FIELD_W) ? f[EW-1] : 1'b0;
        return {{(IW-EW){sgn}}, f[EW-1:0]};
    endfunction

    // Low bits of a W-bit result placed in a 16-bit field, zero filled.
    function automatic logic [OUT_FIELD_W-1:0] fit_out(input logic [ELEMENT_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_FIELD_W-1:0];
    endfunction

    // Saturated signed quotient from magnitude and sign.
    function automatic logic [ELEMENT_WIDTH-1:0] sat_div(input logic [DW-1:0] q,
                                                         input logic neg);
        logic [63:0] q64;
        logic [63:0] mx;
        q64 = 64'(q);
        mx  = LIMIT - 64'd1;
        if (q64 >= LIMIT)
            return neg ? LIMIT[ELEMENT_WIDTH-1:0] : mx[ELEMENT_WIDTH-1:0];
        return neg ? (~q64[ELEMENT_WIDTH-1:0] + 1'b1) : q64[ELEMENT_WIDTH-1:0];
    endfunction

    logic en;
    logic out_vld_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [TUSER_W-1:0]    out_user_reg;

    // The pipeline moves as one whenever the output register can take a result.
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Input stage: extended elements.
    logic                 in_vld_reg;
    logic signed [IW-1:0] e_reg [0:NUM_ELEM-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (en)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_ELEM; i++)
                e_reg[i] <= ext_elem(s_tdata[i*IN_FIELD_W +: IN_FIELD_W]);
        end
    end

    // Branch choice, radicand and numerators.
    logic                  sq_vld_reg  [0:H];
    sq_t                   sq_reg      [0:H];
    side_t                 sq_side_reg [0:H];
    logic signed [TW-1:0]  tr_sum;
    logic signed [TW-1:0]  best;
    branch_t               br_sel;
    logic signed [RSW-1:0] rad;
    logic signed [RSW-1:0] one_v;
    side_t                 side_next;
    sq_t                   sq0_next;

    always_comb
    begin
        one_v  = RSW'(1) <<< FRAC_BITS;
        tr_sum = TW'(e_reg[0]) + TW'(e_reg[4]) + TW'(e_reg[8]);
        best   = tr_sum;
        br_sel = BR_TRACE;
        if (best < TW'(e_reg[0]))
        begin
            br_sel = BR_M00;
            best   = TW'(e_reg[0]);
        end
        if (best < TW'(e_reg[4]))
        begin
            br_sel = BR_M11;
            best   = TW'(e_reg[4]);
        end
        if (best < TW'(e_reg[8]))
            br_sel = BR_M22;

        side_next.br = br_sel;
        unique case (br_sel)
            BR_TRACE:
            begin
                rad = one_v + RSW'(e_reg[0]) + RSW'(e_reg[4]) + RSW'(e_reg[8]);
                side_next.n0 = NSW'(e_reg[7]) - NSW'(e_reg[5]);
                side_next.n1 = NSW'(e_reg[2]) - NSW'(e_reg[6]);
                side_next.n2 = NSW'(e_reg[3]) - NSW'(e_reg[1]);
            end
            BR_M00:
            begin
                rad = one_v + RSW'(e_reg[0]) - RSW'(e_reg[4]) - RSW'(e_reg[8]);
                side_next.n0 = NSW'(e_reg[7]) - NSW'(e_reg[5]);
                side_next.n1 = NSW'(e_reg[1]) + NSW'(e_reg[3]);
                side_next.n2 = NSW'(e_reg[2]) + NSW'(e_reg[6]);
            end
            BR_M11:
            begin
                rad = one_v - RSW'(e_reg[0]) + RSW'(e_reg[4]) - RSW'(e_reg[8]);
                side_next.n0 = NSW'(e_reg[2]) - NSW'(e_reg[6]);
                side_next.n1 = NSW'(e_reg[1]) + NSW'(e_reg[3]);
                side_next.n2 = NSW'(e_reg[5]) + NSW'(e_reg[7]);
            end
            default:
            begin
                rad = one_v - RSW'(e_reg[0]) - RSW'(e_reg[4]) + RSW'(e_reg[8]);
                side_next.n0 = NSW'(e_reg[3]) - NSW'(e_reg[1]);
                side_next.n1 = NSW'(e_reg[2]) + NSW'(e_reg[6]);
                side_next.n2 = NSW'(e_reg[5]) + NSW'(e_reg[7]);
            end
        endcase
        side_next.dg  = (rad <= 0);
        sq0_next.x    = side_next.dg ? '0 : (XW'(rad[RB-1:0]) << FRAC_BITS);
        sq0_next.rem  = '0;
        sq0_next.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg[0] <= 1'b0;
        else if (en)
            sq_vld_reg[0] <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0]      <= sq0_next;
            sq_side_reg[0] <= side_next;
        end
    end

    // Square root, one root bit per stage.
    for (genvar k = 1; k <= H; k++)
    begin : g_sqrt
        logic [RMW+1:0] remsh;
        logic [RMW+2:0] trial;
        sq_t            sq_next;

        always_comb
        begin
            remsh = {sq_reg[k-1].rem, sq_reg[k-1].x[XW-1 -: 2]};
            trial = {1'b0, remsh} - (RMW+3)'({sq_reg[k-1].root, 2'b01});
            sq_next.x = sq_reg[k-1].x << 2;
            if (!trial[RMW+2])
            begin
                sq_next.rem  = trial[RMW-1:0];
                sq_next.root = {sq_reg[k-1].root[H-2:0], 1'b1};
            end
            else
            begin
                sq_next.rem  = remsh[RMW-1:0];
                sq_next.root = {sq_reg[k-1].root[H-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k] <= 1'b0;
            else if (en)
                sq_vld_reg[k] <= sq_vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[k]      <= sq_next;
                sq_side_reg[k] <= sq_side_reg[k-1];
            end
        end
    end

    // Divider setup: denominator 2*S, magnitudes and signs of the numerators.
    logic   dv_vld_reg  [0:DW];
    dv_t    dv_reg      [0:DW][0:2];
    dside_t dv_side_reg [0:DW];
    dside_t dside_next;
    dv_t    dv0_next [0:2];
    logic signed [NSW-1:0] nsel [0:2];

    always_comb
    begin
        nsel[0] = sq_side_reg[H].n0;
        nsel[1] = sq_side_reg[H].n1;
        nsel[2] = sq_side_reg[H].n2;
        dside_next.br   = sq_side_reg[H].br;
        dside_next.dg   = sq_side_reg[H].dg;
        dside_next.den  = {sq_reg[H].root, 1'b0};
        dside_next.prim = sq_reg[H].root[H-1:1];
        for (int i = 0; i < 3; i++)
        begin
            dside_next.neg[i] = nsel[i][NSW-1];
            dv0_next[i].d   = DW'(nsel[i][NSW-1] ? (~nsel[i] + 1'b1) : nsel[i]) << FRAC_BITS;
            dv0_next[i].rem = '0;
            dv0_next[i].q   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else if (en)
            dv_vld_reg[0] <= sq_vld_reg[H];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side_reg[0] <= dside_next;
            for (int i = 0; i < 3; i++)
                dv_reg[0][i] <= dv0_next[i];
        end
    end

    // Three restoring dividers, one quotient bit per stage.
    for (genvar j = 1; j <= DW; j++)
    begin : g_div
        dv_t dv_next [0:2];

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic [H+1:0] rsh;
                logic [H+1:0] dn;
                rsh = {dv_reg[j-1][i].rem, dv_reg[j-1][i].d[DW-1]};
                dn  = {1'b0, dv_side_reg[j-1].den};
                dv_next[i].d = dv_reg[j-1][i].d << 1;
                if (rsh >= dn)
                begin
                    dv_next[i].rem = H'(rsh - dn) == '0 ? '0 : (H+1)'(rsh - dn);
                    dv_next[i].q   = {dv_reg[j-1][i].q[DW-2:0], 1'b1};
                end
                else
                begin
                    dv_next[i].rem = rsh[H:0];
                    dv_next[i].q   = {dv_reg[j-1][i].q[DW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[j] <= 1'b0;
            else if (en)
                dv_vld_reg[j] <= dv_vld_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_side_reg[j] <= dv_side_reg[j-1];
                for (int i = 0; i < 3; i++)
                    dv_reg[j][i] <= dv_next[i];
            end
        end
    end

    // Saturation, placement by branch, output register.
    logic [ELEMENT_WIDTH-1:0] qa;
    logic [ELEMENT_WIDTH-1:0] qb;
    logic [ELEMENT_WIDTH-1:0] qc;
    logic [ELEMENT_WIDTH-1:0] qp;
    logic [63:0]              prim64;
    logic [63:0]              pmax;
    logic [OUT_FIELD_W-1:0]   fw;
    logic [OUT_FIELD_W-1:0]   fx;
    logic [OUT_FIELD_W-1:0]   fy;
    logic [OUT_FIELD_W-1:0]   fz;
    logic [OUT_DATA_W-1:0]    data_next;
    logic [TUSER_W-1:0]       user_next;

    always_comb
    begin
        qa     = sat_div(dv_reg[DW][0].q, dv_side_reg[DW].neg[0]);
        qb     = sat_div(dv_reg[DW][1].q, dv_side_reg[DW].neg[1]);
        qc     = sat_div(dv_reg[DW][2].q, dv_side_reg[DW].neg[2]);
        prim64 = 64'(dv_side_reg[DW].prim);
        pmax   = LIMIT - 64'd1;
        qp     = (prim64 > pmax) ? pmax[ELEMENT_WIDTH-1:0] : prim64[ELEMENT_WIDTH-1:0];
        unique case (dv_side_reg[DW].br)
            BR_TRACE:
            begin
                fw = fit_out(qp); fx = fit_out(qa); fy = fit_out(qb); fz = fit_out(qc);
            end
            BR_M00:
            begin
                fw = fit_out(qa); fx = fit_out(qp); fy = fit_out(qb); fz = fit_out(qc);
            end
            BR_M11:
            begin
                fw = fit_out(qa); fx = fit_out(qb); fy = fit_out(qp); fz = fit_out(qc);
            end
            default:
            begin
                fw = fit_out(qa); fx = fit_out(qb); fy = fit_out(qc); fz = fit_out(qp);
            end
        endcase
        data_next = dv_side_reg[DW].dg ? '0 : {fz, fy, fx, fw};
        user_next = {dv_side_reg[DW].dg, dv_side_reg[DW].br};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= dv_vld_reg[DW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= data_next;
            out_user_reg <= user_next;
        end
    end

endmodule

[hdl/r2q_chk.sv]
module r2q_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [r2q_pkg::IN_DATA_W-1:0]   s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [r2q_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [r2q_pkg::TUSER_W-1:0]     m_tuser
);
    import r2q_pkg::*;

    // A held result stays valid and unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The input side is open exactly when the output can move.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output state");

    // A degenerate matrix gives an all-zero quaternion.
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[TUSER_DEGEN] |-> m_tdata == '0)
        else $error("degenerate result carries nonzero data");

    // No result right after reset is released.
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind rotation_matrix_to_quaternion r2q_chk u_r2q_chk (.*);

[tb/rotation_matrix_to_quaternion_tb.sv]
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;
    import r2q_pkg::*;

    localparam int FRAC    = 14;
    localparam int ONE_Q   = 1 << FRAC;
    localparam int NUM_DIR = 12;
    localparam int NUM_RND = 650;
    localparam int DRAIN   = 120;

    // One expected quaternion with its branch and flag.
    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        branch_t            br;
        logic               degen;
    } quat_t;

    // A directed row: the matrix, and a typed-in result where one is given.
    typedef struct packed {
        logic [IN_DATA_W-1:0] mat;
        logic                 typed;
        quat_t                q;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // m00 m01 m02 m10 m11 m12 m20 m21 m22
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // quat_w quat_x quat_y quat_z
    logic [TUSER_W-1:0]    m_tuser;   // branch_taken degenerate

    quat_t    quat_fifo[$];
    dir_row_t dir_tbl[NUM_DIR];
    int       cyc;
    int       sent;
    int       got;
    int       errors;
    int       branch_seen[4];
    bit       sending_done;

    rotation_matrix_to_quaternion dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock and cycle counter.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    function automatic logic [IN_DATA_W-1:0] pack9(input int a0, a1, a2, b0, b1, b2,
                                                   c0, c1, c2);
        logic [15:0] e[9];
        logic [IN_DATA_W-1:0] v;
        e[0] = 16'(a0); e[1] = 16'(a1); e[2] = 16'(a2);
        e[3] = 16'(b0); e[4] = 16'(b1); e[5] = 16'(b2);
        e[6] = 16'(c0); e[7] = 16'(c1); e[8] = 16'(c2);
        for (int i = 0; i < 9; i++)
            v[i*16 +: 16] = e[i];
        return v;
    endfunction

    // Integer square root, bit by bit.
    function automatic longint unsigned int_sqrt(input longint unsigned val);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > val)
            b = b >> 2;
        while (b != 0)
        begin
            if (val >= r + b)
            begin
                val = val - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Fixed-point quotient num * ONE / den, truncated toward zero and saturated.
    function automatic longint frac_div(input longint num, input longint unsigned den);
        longint unsigned mag;
        longint unsigned qt;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        qt = (mag << FRAC) / den;
        if (qt > 32768)
            qt = 32768;
        return clamp16((num < 0) ? -longint'(qt) : longint'(qt));
    endfunction

    // Shepperd's method on one packed matrix.
    function automatic quat_t shepperd_quat(input logic [IN_DATA_W-1:0] d);
        longint m[9];
        longint best, rad, n0, n1, n2, prim, a, b, c;
        longint unsigned s;
        branch_t br;
        quat_t q;
        for (int i = 0; i < 9; i++)
            m[i] = longint'($signed(d[i*16 +: 16]));
        best = m[0] + m[4] + m[8];
        br = BR_TRACE;
        if (best < m[0]) begin br = BR_M00; best = m[0]; end
        if (best < m[4]) begin br = BR_M11; best = m[4]; end
        if (best < m[8]) br = BR_M22;
        case (br)
            BR_TRACE:
            begin
                rad = ONE_Q + m[0] + m[4] + m[8];
                n0 = m[7] - m[5]; n1 = m[2] - m[6]; n2 = m[3] - m[1];
            end
            BR_M00:
            begin
                rad = ONE_Q + m[0] - m[4] - m[8];
                n0 = m[7] - m[5]; n1 = m[1] + m[3]; n2 = m[2] + m[6];
            end
            BR_M11:
            begin
                rad = ONE_Q - m[0] + m[4] - m[8];
                n0 = m[2] - m[6]; n1 = m[1] + m[3]; n2 = m[5] + m[7];
            end
            default:
            begin
                rad = ONE_Q - m[0] - m[4] + m[8];
                n0 = m[3] - m[1]; n1 = m[2] + m[6]; n2 = m[5] + m[7];
            end
        endcase
        q = '0;
        q.br = br;
        if (rad <= 0)
            q.degen = 1'b1;
        else
        begin
            s = int_sqrt(longint'(rad) << FRAC);
            prim = clamp16(longint'(s >> 1));
            a = frac_div(n0, 2 * s);
            b = frac_div(n1, 2 * s);
            c = frac_div(n2, 2 * s);
            case (br)
                BR_TRACE:
                begin
                    q.w = 16'(prim); q.x = 16'(a); q.y = 16'(b); q.z = 16'(c);
                end
                BR_M00:
                begin
                    q.x = 16'(prim); q.w = 16'(a); q.y = 16'(b); q.z = 16'(c);
                end
                BR_M11:
                begin
                    q.y = 16'(prim); q.w = 16'(a); q.x = 16'(b); q.z = 16'(c);
                end
                default:
                begin
                    q.z = 16'(prim); q.w = 16'(a); q.x = 16'(b); q.y = 16'(c);
                end
            endcase
        end
        return q;
    endfunction

    // Random rotation from a random quaternion, rounded to Q1.14 and clipped to +-1.0.
    function automatic logic [IN_DATA_W-1:0] random_rotation();
        real qw, qx, qy, qz, nrm;
        real r[9];
        int e[9];
        logic [IN_DATA_W-1:0] v;
        qw = $itor($urandom_range(0, 2000)) - 1000.0;
        qx = $itor($urandom_range(0, 2000)) - 1000.0;
        qy = $itor($urandom_range(0, 2000)) - 1000.0;
        qz = $itor($urandom_range(0, 2000)) - 1000.0;
        nrm = $sqrt(qw*qw + qx*qx + qy*qy + qz*qz);
        if (nrm < 1.0)
        begin
            qw = 1.0; nrm = 1.0;
        end
        qw = qw / nrm; qx = qx / nrm; qy = qy / nrm; qz = qz / nrm;
        r[0] = 1.0 - 2.0*(qy*qy + qz*qz);
        r[1] = 2.0*(qx*qy - qz*qw);
        r[2] = 2.0*(qx*qz + qy*qw);
        r[3] = 2.0*(qx*qy + qz*qw);
        r[4] = 1.0 - 2.0*(qx*qx + qz*qz);
        r[5] = 2.0*(qy*qz - qx*qw);
        r[6] = 2.0*(qx*qz - qy*qw);
        r[7] = 2.0*(qy*qz + qx*qw);
        r[8] = 1.0 - 2.0*(qx*qx + qy*qy);
        for (int i = 0; i < 9; i++)
        begin
            e[i] = $rtoi(r[i] * 16384.0 + ((r[i] < 0.0) ? -0.5 : 0.5));
            if (e[i] > ONE_Q)
                e[i] = ONE_Q;
            if (e[i] < -ONE_Q)
                e[i] = -ONE_Q;
            v[i*16 +: 16] = 16'(e[i]);
        end
        return v;
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_noise();
        logic [IN_DATA_W-1:0] v;
        for (int i = 0; i < 9; i++)
            v[i*16 +: 16] = 16'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
        return v;
    endfunction

    // Random idling, except through one long quiet window.
    function automatic bit take_gap();
        if (cyc >= 700 && cyc < 900)
            return 1'b0;
        return $urandom_range(0, 99) < 33;
    endfunction

    // Offer one request and wait until it is taken; the expectation is queued then.
    task automatic send_matrix(input logic [IN_DATA_W-1:0] mat, input bit typed,
                               input quat_t q);
        quat_t calc;
        @(negedge clk);
        while (take_gap())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mat;
        do
            @(posedge clk);
        while (!s_tready);
        calc = shepperd_quat(mat);
        if (typed && calc != q)
            $display("directed row %0d: typed result %h disagrees with predictor %h",
                     sent, q, calc);
        quat_fifo.push_back(typed ? q : calc);
        branch_seen[calc.br]++;
        sent++;
    endtask

    // Directed rows.
    initial
    begin
        dir_tbl[0]  = '{pack9(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q), 1'b1,
                        '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, BR_TRACE, 1'b0}};
        dir_tbl[1]  = '{pack9(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        '{16'sd8192, 16'sd0, 16'sd0, 16'sd0, BR_TRACE, 1'b0}};
        dir_tbl[2]  = '{pack9(ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q), 1'b1,
                        '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, BR_M00, 1'b0}};
        dir_tbl[3]  = '{pack9(-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q), 1'b1,
                        '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, BR_M11, 1'b0}};
        dir_tbl[4]  = '{pack9(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q), 1'b1,
                        '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, BR_M22, 1'b0}};
        dir_tbl[5]  = '{pack9(ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q,
                              ONE_Q), 1'b0, '0};
        dir_tbl[6]  = '{pack9(-ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q,
                              -ONE_Q, -ONE_Q), 1'b0, '0};
        // Ties between diagonal entries go to the earlier one.
        dir_tbl[7]  = '{pack9(8192, 100, -200, 300, 8192, -400, 500, -600, -9000),
                        1'b0, '0};
        dir_tbl[8]  = '{pack9(-9000, ONE_Q, -ONE_Q, ONE_Q, 7000, ONE_Q, -ONE_Q, ONE_Q,
                              7000), 1'b0, '0};
        dir_tbl[9]  = '{pack9(0, -ONE_Q, ONE_Q, ONE_Q, 0, -ONE_Q, -ONE_Q, ONE_Q, -1),
                        1'b0, '0};
        // Ninety degrees about z, then a mixed extreme pattern.
        dir_tbl[10] = '{pack9(0, -ONE_Q, 0, ONE_Q, 0, 0, 0, 0, ONE_Q), 1'b0, '0};
        dir_tbl[11] = '{pack9(-ONE_Q, ONE_Q, -ONE_Q, ONE_Q, -1, ONE_Q, -ONE_Q, ONE_Q, 0),
                        1'b0, '0};
    end

    // Reset and stimulus.
    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cyc          = 0;
        sent         = 0;
        sending_done = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int i = 0; i < NUM_DIR; i++)
            send_matrix(dir_tbl[i].mat, dir_tbl[i].typed, dir_tbl[i].q);
        for (int i = 0; i < NUM_RND; i++)
            send_matrix(($urandom_range(0, 99) < 70) ? random_rotation() : random_noise(),
                        1'b0, '0);
        @(negedge clk);
        s_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: random back-pressure plus one long hold-off.
    initial
    begin
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && sent >= 200)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            m_tready <= !take_gap();
        end
    end

    // Compare each taken result with the oldest expectation.
    always @(posedge clk)
    begin
        quat_t act;
        quat_t exp_q;
        if (rst_n && m_tvalid && m_tready)
        begin
            act.w     = m_tdata[15:0];
            act.x     = m_tdata[31:16];
            act.y     = m_tdata[47:32];
            act.z     = m_tdata[63:48];
            act.br    = branch_t'(m_tuser[1:0]);
            act.degen = m_tuser[TUSER_DEGEN];
            got++;
            if (quat_fifo.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", act);
            end
            else
            begin
                exp_q = quat_fifo.pop_front();
                if (act != exp_q)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"result %0d: exp w=%0d x=%0d y=%0d z=%0d br=%0d dg=%0b,",
                                  " got w=%0d x=%0d y=%0d z=%0d br=%0d dg=%0b"},
                                 got, exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.br,
                                 exp_q.degen, act.w, act.x, act.y, act.z, act.br,
                                 act.degen);
                end
            end
        end
    end

    // End of run.
    initial
    begin
        errors = 0;
        got    = 0;
        for (int i = 0; i < 4; i++)
            branch_seen[i] = 0;
        wait (sending_done);
        while (quat_fifo.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (quat_fifo.size() != 0)
            errors++;
        $display("Sent %0d matrices (%0d directed), %0d quaternions checked.",
                 sent, NUM_DIR, got);
        $display("Branches: trace %0d, m00 %0d, m11 %0d, m22 %0d; mismatches %0d.",
                 branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3], errors);
        if (errors == 0)
            $display("rotation_matrix_to_quaternion verification clean");
        else
            $display("rotation_matrix_to_quaternion verification failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5ms;
        $display("rotation_matrix_to_quaternion verification failed");
        $finish;
    end

endmodule
